FILE: sv/iie_pkg.sv
package iie_pkg;

   localparam int CHAR_W   = 8;
   localparam int VALUE_W  = 64;
   localparam int NUM_W    = 31;
   localparam int STATUS_W = 2;
   localparam int QUEUE_DEPTH_DEF = 4;

   localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;
   localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
   localparam logic [CHAR_W-1:0] CH_STAR  = 8'h2A;
   localparam logic [CHAR_W-1:0] CH_SLASH = 8'h2F;
   localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
   localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;

   localparam logic [NUM_W-1:0] NUM_MAX = 31'h7FFF_FFFF;

   localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
   localparam logic [STATUS_W-1:0] ST_DIV_ZERO = 2'd1;
   localparam logic [STATUS_W-1:0] ST_MALFORM  = 2'd2;
   localparam logic [STATUS_W-1:0] ST_OVERFLOW = 2'd3;

   // operation codes passed from front to back
   typedef enum logic [1:0] {
      OP_NONE = 2'd0,
      OP_MUL  = 2'd1,
      OP_DIV  = 2'd2
   } op_type;

   // one command for the back end: close a number and fold it
   typedef struct packed {
      logic [NUM_W-1:0] number;   // number being closed
      op_type           op;       // pending high-precedence operator
      logic             add_term; // add term to sum afterward
      logic             term_neg; // sign of the term when it is added
      logic             finish;   // emit result and clear
      logic [STATUS_W-1:0] status; // final status (valid on finish)
   } cmd_type;

endpackage

FILE: sv/iie_front.sv
module iie_front (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic [iie_pkg::CHAR_W-1:0] req_ch,
   input  logic                   req_last,
   output logic                   cmd_valid,
   input  logic                   cmd_full,
   output iie_pkg::cmd_type       cmd_data
);
   import iie_pkg::*;

   logic [NUM_W-1:0]    num_ff, num_in;
   logic                in_num_ff, in_num_in;
   logic                start_ff, start_in;
   logic                neg_ff, neg_in;
   op_type              op_ff, op_in;
   logic [STATUS_W-1:0] err_ff, err_in;

   logic       is_digit, is_add, is_mul, take, close;
   logic [3:0] dig;
   logic [34:0] prod;
   logic [STATUS_W-1:0] err_mid, err_fin;

   assign req_stall = cmd_full;
   assign take      = req_valid && !cmd_full;
   assign is_digit  = (req_ch >= CH_ZERO) && (req_ch <= CH_NINE);
   assign is_add    = (req_ch == CH_PLUS) || (req_ch == CH_MINUS);
   assign is_mul    = (req_ch == CH_STAR) || (req_ch == CH_SLASH);
   assign dig       = 4'(req_ch - CH_ZERO);
   assign prod      = 35'({num_ff, 3'b000}) + 35'({num_ff, 1'b0}) + 35'(dig);

   // classify the character and build the command
   always_comb begin
      num_in = num_ff; in_num_in = in_num_ff; start_in = 1'b0;
      neg_in = neg_ff; op_in = op_ff; err_mid = err_ff;
      close = 1'b0;
      cmd_data  = '0;
      cmd_data.number   = num_ff;
      cmd_data.op       = op_ff;
      cmd_data.term_neg = neg_ff;
      if (is_digit) begin
         if (prod > 35'(NUM_MAX)) begin
            num_in = NUM_MAX;
            if (err_ff == ST_OK) err_mid = ST_OVERFLOW;
         end else begin
            num_in = NUM_W'(prod);
         end
         in_num_in = 1'b1;
      end else if (is_add) begin
         if (in_num_ff) begin
            close = 1'b1;
            cmd_data.add_term = 1'b1;
            num_in = '0; in_num_in = 1'b0; op_in = OP_NONE;
            neg_in = (req_ch == CH_MINUS);
         end else if (start_ff && req_ch == CH_MINUS) begin
            neg_in = 1'b1;
         end else if (err_ff == ST_OK) begin
            err_mid = ST_MALFORM;
         end
      end else if (is_mul) begin
         if (in_num_ff) begin
            close = 1'b1;
            num_in = '0; in_num_in = 1'b0;
            op_in = (req_ch == CH_STAR) ? OP_MUL : OP_DIV;
         end else if (err_ff == ST_OK) begin
            err_mid = ST_MALFORM;
         end
      end
      // closing a number of zero under a pending divide
      if (close && op_ff == OP_DIV && num_ff == '0 && err_mid == ST_OK)
         err_mid = ST_DIV_ZERO;
      cmd_valid = close;
      err_in  = err_mid;
      err_fin = err_mid;
      if (req_last) begin
         // a closing command carries the final number and status
         cmd_valid = 1'b1;
         cmd_data.add_term = 1'b0;
         cmd_data.finish   = 1'b1;
         if (!close) begin
            cmd_data.number   = num_in;
            cmd_data.op       = op_in;
            cmd_data.term_neg = neg_in;
            if (op_in == OP_DIV && num_in == '0 && err_fin == ST_OK)
               err_fin = ST_DIV_ZERO;
         end else if (req_ch == CH_STAR) begin
            // "a*" ends on an empty number, so the term drops to zero
            cmd_data.number = '0;
            cmd_data.op     = OP_MUL;
         end else if (req_ch == CH_SLASH) begin
            // "a/" ends dividing by the empty number
            if (err_fin == ST_OK) err_fin = ST_DIV_ZERO;
         end
         cmd_data.status = err_fin;
         num_in = '0; in_num_in = 1'b0; start_in = 1'b1;
         neg_in = 1'b0; op_in = OP_NONE; err_in = ST_OK;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         num_ff <= '0; in_num_ff <= 1'b0; start_ff <= 1'b1;
         neg_ff <= 1'b0; op_ff <= OP_NONE; err_ff <= ST_OK;
      end else if (take) begin
         num_ff <= num_in; in_num_ff <= in_num_in; start_ff <= start_in;
         neg_ff <= neg_in; op_ff <= op_in; err_ff <= err_in;
      end
   end

   // only the first error is kept
   a_err_sticky: assert property (@(posedge clock) disable iff (reset)
      (take && err_ff != ST_OK && !req_last) |=> (err_ff == $past(err_ff)))
      else $error("front error code changed");
   a_num_max: assert property (@(posedge clock) disable iff (reset)
      num_ff <= NUM_MAX) else $error("number above limit");
   a_last_cmd: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_last) |-> cmd_valid) else $error("last without command");
endmodule

FILE: sv/iie_queue.sv
module iie_queue #(
   parameter int DEPTH = iie_pkg::QUEUE_DEPTH_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  iie_pkg::cmd_type push_data,
   output logic             full,
   output logic             pop_valid,
   input  logic             pop,
   output iie_pkg::cmd_type pop_data
);
   import iie_pkg::*;
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   cmd_type        mem_ff [DEPTH];
   logic [AW-1:0]  wr_ff, rd_ff;
   logic [AW:0]    cnt_ff;

   assign full      = (cnt_ff == (AW+1)'(DEPTH));
   assign pop_valid = (cnt_ff != '0);
   assign pop_data  = mem_ff[rd_ff];

   always_ff @(posedge clock) begin
      if (push && !full) mem_ff[wr_ff] <= push_data;
   end

   // pointer and count update
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff <= '0; rd_ff <= '0; cnt_ff <= '0;
      end else begin
         if (push && !full)
            wr_ff <= (wr_ff == AW'(DEPTH-1)) ? '0 : wr_ff + 1'b1;
         if (pop && pop_valid)
            rd_ff <= (rd_ff == AW'(DEPTH-1)) ? '0 : rd_ff + 1'b1;
         cnt_ff <= cnt_ff + (AW+1)'(push && !full) - (AW+1)'(pop && pop_valid);
      end
   end

   a_cnt: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= (AW+1)'(DEPTH)) else $error("queue count out of range");
endmodule

FILE: sv/iie_back.sv
module iie_back (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      cmd_valid,
   output logic                      cmd_pop,
   input  iie_pkg::cmd_type          cmd_data,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic signed [iie_pkg::VALUE_W-1:0] rsp_value,
   output logic [iie_pkg::STATUS_W-1:0]       rsp_status
);
   import iie_pkg::*;

   typedef enum logic [2:0] {S_IDLE, S_MUL, S_DIV, S_DIVFIX, S_ADD, S_OUT} state_type;

   state_type        state_ff;
   logic [VALUE_W-1:0] sum_ff, term_ff, acc_ff, rem_ff, quo_ff;
   logic [NUM_W-1:0]   n_ff;
   logic [5:0]         cnt_ff;
   logic               qneg_ff;
   cmd_type            cur_ff;
   logic signed [VALUE_W-1:0] val_ff;
   logic [STATUS_W-1:0] st_ff;
   logic               out_ff;

   logic [VALUE_W:0]   rem_sh;
   logic [VALUE_W-1:0] mag, pp;

   assign rsp_valid  = out_ff;
   assign rsp_value  = val_ff;
   assign rsp_status = st_ff;
   assign cmd_pop    = (state_ff == S_IDLE) && cmd_valid;
   assign mag        = cmd_data.op == OP_DIV && term_ff[VALUE_W-1] ? -term_ff : term_ff;
   assign rem_sh     = {rem_ff, quo_ff[VALUE_W-1]};
   assign pp         = {32'd0, acc_ff[31:0]} * {33'd0, n_ff};

   // sequencer: multiply by 32-bit chunks, divide one bit a cycle
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE; out_ff <= 1'b0;
         sum_ff <= '0; term_ff <= '0;
      end else begin
         if (out_ff && !rsp_stall && !(state_ff == S_ADD && cur_ff.finish)) out_ff <= 1'b0;
         unique case (state_ff)
            S_IDLE: if (cmd_valid) begin
               cur_ff <= cmd_data;
               n_ff   <= cmd_data.number;
               unique case (cmd_data.op)
                  OP_MUL: begin
                     acc_ff <= term_ff; term_ff <= '0; cnt_ff <= '0;
                     state_ff <= S_MUL;
                  end
                  OP_DIV: begin
                     if (cmd_data.number == '0) begin
                        // divide by zero leaves the term as it is
                        state_ff <= S_ADD;
                     end else begin
                        qneg_ff <= term_ff[VALUE_W-1];
                        quo_ff <= mag; rem_ff <= '0; cnt_ff <= '0;
                        state_ff <= S_DIV;
                     end
                  end
                  default: begin
                     term_ff <= {33'd0, cmd_data.number}; state_ff <= S_ADD;
                  end
               endcase
            end
            S_MUL: begin
               // two chunks: low half then high half shifted
               if (cnt_ff == '0) begin
                  term_ff <= pp; acc_ff <= {32'd0, acc_ff[63:32]}; cnt_ff <= 6'd1;
               end else begin
                  term_ff <= term_ff + {pp[31:0], 32'd0}; state_ff <= S_ADD;
               end
            end
            S_DIV: begin
               if (rem_sh >= {34'd0, n_ff}) begin
                  rem_ff <= VALUE_W'(rem_sh - {34'd0, n_ff});
                  quo_ff <= {quo_ff[VALUE_W-2:0], 1'b1};
               end else begin
                  rem_ff <= VALUE_W'(rem_sh);
                  quo_ff <= {quo_ff[VALUE_W-2:0], 1'b0};
               end
               cnt_ff <= cnt_ff + 1'b1;
               if (cnt_ff == 6'd63) state_ff <= S_DIVFIX;
            end
            S_DIVFIX: begin
               term_ff <= qneg_ff ? -quo_ff : quo_ff; state_ff <= S_ADD;
            end
            S_ADD: begin
               if (cur_ff.finish) begin
                  // result waits here while the previous one is stalled
                  if (!out_ff || !rsp_stall) begin
                     st_ff <= cur_ff.status;
                     val_ff <= (cur_ff.status == ST_DIV_ZERO ||
                                cur_ff.status == ST_MALFORM) ? '0 :
                               sum_ff + (cur_ff.term_neg ? -term_ff : term_ff);
                     out_ff <= 1'b1;
                     sum_ff <= '0; term_ff <= '0;
                     state_ff <= S_IDLE;
                  end
               end else if (cur_ff.add_term) begin
                  sum_ff <= sum_ff + (cur_ff.term_neg ? -term_ff : term_ff);
                  term_ff <= '0;
                  state_ff <= S_IDLE;
               end else begin
                  state_ff <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   a_out_hold: assert property (@(posedge clock) disable iff (reset)
      (out_ff && rsp_stall) |=> (out_ff && $stable(val_ff)))
      else $error("result dropped under stall");
   a_div_cnt: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DIV && cnt_ff != 6'd63) |=> state_ff == S_DIV)
      else $error("divide left early");
   a_no_pop_busy: assert property (@(posedge clock) disable iff (reset)
      cmd_pop |-> state_ff == S_IDLE) else $error("pop while busy");
endmodule

FILE: sv/infix_integer_expression_evaluator.sv
// Channel  Ports                       Direction
// req      req_valid/stall ch last     in
// rsp      rsp_valid/stall value status out
// One character per cycle into the front while req_stall is low; a command
// holds the back through S_MUL for *, through S_DIV and S_DIVFIX for / (radix-2
// divider), and a finished result waits in S_ADD while rsp_stall is high.
// Synchronous active-high reset clears state, queue and the result valid flag.
// The command queue (four entries by default) lets the front take characters while the back
// computes; req_stall rises only when the queue is full.
module infix_integer_expression_evaluator #(
   parameter int QUEUE_DEPTH = iie_pkg::QUEUE_DEPTH_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [iie_pkg::CHAR_W-1:0]        req_ch,
   input  logic                              req_last,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic signed [iie_pkg::VALUE_W-1:0] rsp_value,
   output logic [iie_pkg::STATUS_W-1:0]      rsp_status
);
   import iie_pkg::*;

   cmd_type f_cmd, b_cmd;
   logic    f_valid, q_full, q_valid, q_pop;

   iie_front u_front (
      .clock, .reset, .req_valid, .req_stall, .req_ch, .req_last,
      .cmd_valid(f_valid), .cmd_full(q_full), .cmd_data(f_cmd)
   );

   iie_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
      .clock, .reset, .push(f_valid && req_valid), .push_data(f_cmd),
      .full(q_full), .pop_valid(q_valid), .pop(q_pop), .pop_data(b_cmd)
   );

   iie_back u_back (
      .clock, .reset, .cmd_valid(q_valid), .cmd_pop(q_pop), .cmd_data(b_cmd),
      .rsp_valid, .rsp_stall, .rsp_value, .rsp_status
   );
endmodule

FILE: tb/sv/iie_checker.sv
module iie_checker (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   input  logic                               req_stall,
   input  logic [iie_pkg::CHAR_W-1:0]         req_ch,
   input  logic                               req_last,
   input  logic                               rsp_valid,
   input  logic                               rsp_stall,
   input  logic signed [iie_pkg::VALUE_W-1:0] rsp_value,
   input  logic [iie_pkg::STATUS_W-1:0]       rsp_status,
   output int                                 fail_count,
   output int                                 pending_count,
   output int                                 result_count,
   output logic                               any_transfer
);
   timeunit 1ns;
   timeprecision 1ps;
   import iie_pkg::*;

   typedef struct packed {
      logic [VALUE_W-1:0]  value;
      logic [STATUS_W-1:0] status;
   } result_type;

   result_type expected_results[$];

   // expression state of the predictor
   logic [VALUE_W-1:0]  sum;
   logic [VALUE_W-1:0]  term;
   logic                term_neg;
   op_type              pend_op;
   logic [NUM_W-1:0]    number;
   logic                in_num;
   logic                first_char;
   logic [STATUS_W-1:0] err;

   function automatic void clear_expression();
      sum = '0;
      term = '0;
      term_neg = 1'b0;
      pend_op = OP_NONE;
      number = '0;
      in_num = 1'b0;
      first_char = 1'b1;
      err = ST_OK;
   endfunction

   function automatic void flag(input logic [STATUS_W-1:0] code);
      if (err == ST_OK) err = code;
   endfunction

   // fold the closed number into the running term
   function automatic void close_number();
      logic [VALUE_W-1:0] n;
      logic [VALUE_W-1:0] mag;
      n = VALUE_W'(number);
      case (pend_op)
         OP_MUL: begin
            term = term * n;
         end
         OP_DIV: begin
            if (n == 0) begin
               flag(ST_DIV_ZERO);
            end else if (term[VALUE_W-1]) begin
               mag = -term;
               term = -(mag / n);
            end else begin
               term = term / n;
            end
         end
         default: begin
            term = n;
         end
      endcase
      pend_op = OP_NONE;
      in_num = 1'b0;
      number = '0;
   endfunction

   function automatic void add_term();
      sum = sum + (term_neg ? -term : term);
   endfunction

   // one character of the expression; queues a result on the last one
   function automatic void eval_char(input logic [CHAR_W-1:0] c, input logic fin);
      logic [31:0] d;
      result_type r;
      if (c >= CH_ZERO && c <= CH_NINE) begin
         d = 32'(c - CH_ZERO);
         if (32'(number) > (32'(NUM_MAX) - d) / 10) begin
            number = NUM_MAX;
            flag(ST_OVERFLOW);
         end else begin
            number = NUM_W'(32'(number) * 10 + d);
         end
         in_num = 1'b1;
      end else if (c == CH_PLUS || c == CH_MINUS) begin
         if (in_num) begin
            close_number();
            add_term();
            term = '0;
            term_neg = (c == CH_MINUS);
         end else if (first_char && c == CH_MINUS) begin
            term_neg = 1'b1;
         end else begin
            flag(ST_MALFORM);
         end
      end else if (c == CH_STAR || c == CH_SLASH) begin
         if (in_num) begin
            close_number();
            pend_op = (c == CH_STAR) ? OP_MUL : OP_DIV;
         end else begin
            flag(ST_MALFORM);
         end
      end
      first_char = 1'b0;
      if (fin) begin
         close_number();
         add_term();
         r.value = (err == ST_DIV_ZERO || err == ST_MALFORM) ? '0 : sum;
         r.status = err;
         expected_results.push_back(r);
         clear_expression();
      end
   endfunction

   initial begin
      clear_expression();
      fail_count = 0;
      result_count = 0;
      pending_count = 0;
   end

   assign any_transfer = (req_valid && !req_stall) || (rsp_valid && !rsp_stall);

   // watch both channels
   always @(posedge clock) begin
      result_type want;
      int errs;
      errs = 0;
      if (reset) begin
         clear_expression();
      end else begin
         if (req_valid && !req_stall) eval_char(req_ch, req_last);
         if (rsp_valid && !rsp_stall) begin
            result_count <= result_count + 1;
            if (expected_results.size() == 0) begin
               $error("unexpected result value=%0d status=%0d", rsp_value, rsp_status);
               errs++;
            end else begin
               want = expected_results.pop_front();
               if (rsp_value !== want.value) begin
                  $error("value: expected %0d actual %0d",
                         $signed(want.value), rsp_value);
                  errs++;
               end
               if (rsp_status !== want.status) begin
                  $error("status: expected %0d actual %0d", want.status, rsp_status);
                  errs++;
               end
            end
         end
         fail_count <= fail_count + errs;
      end
      pending_count <= expected_results.size();
   end
endmodule

FILE: tb/sv/tb_infix_integer_expression_evaluator.sv
module tb_infix_integer_expression_evaluator;
   timeunit 1ns;
   timeprecision 1ps;
   import iie_pkg::*;

   localparam int WATCHDOG_LIMIT = 20000;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_stall;
   logic [CHAR_W-1:0]   req_ch = '0;
   logic                req_last = 1'b0;
   logic                rsp_valid;
   logic                rsp_stall = 1'b0;
   logic signed [VALUE_W-1:0] rsp_value;
   logic [STATUS_W-1:0] rsp_status;

   int fail_count;
   int pending_count;
   int result_count;
   logic any_transfer;
   int send_idle_pct = 0;
   int recv_stall_pct = 0;
   int char_count = 0;
   int idle_cycles = 0;

   always #10 clock = ~clock;

   infix_integer_expression_evaluator u_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_ch(req_ch), .req_last(req_last),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_value(rsp_value), .rsp_status(rsp_status)
   );

   iie_checker u_checker (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_ch(req_ch), .req_last(req_last),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_value(rsp_value), .rsp_status(rsp_status),
      .fail_count(fail_count), .pending_count(pending_count),
      .result_count(result_count), .any_transfer(any_transfer)
   );

   // receiver stall
   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(99) < recv_stall_pct);
   end

   // watchdog on cycles with no transfer
   always @(posedge clock) begin
      if (reset || any_transfer) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("watchdog expired");
         $display("RESULT: ERROR");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // one character transfer, with random idle cycles ahead of it
   task automatic send_char(input logic [CHAR_W-1:0] c, input logic fin);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_ch <= c;
      req_last <= fin;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      char_count++;
   endtask

   task automatic send_text(input string s);
      for (int i = 0; i < s.len(); i++) send_char(s[i], i == s.len() - 1);
   endtask

   function automatic string digits(input int n);
      string s;
      s = "";
      for (int i = 0; i < n; i++) s = {s, string'(8'(CH_ZERO + $urandom_range(9)))};
      return s;
   endfunction

   function automatic string rand_op();
      case ($urandom_range(3))
         0: return "+";
         1: return "-";
         2: return "*";
         default: return "/";
      endcase
   endfunction

   // mostly well-formed expressions, some broken or noisy
   function automatic string rand_expr();
      string s;
      int terms;
      int kind;
      s = ($urandom_range(4) == 0) ? "-" : "";
      terms = $urandom_range(1, 4);
      for (int t = 0; t < terms; t++) begin
         kind = $urandom_range(19);
         if (kind == 0) s = {s, digits($urandom_range(10, 12))};
         else if (kind < 3) s = {s, "0"};
         else if (kind < 5) s = {s, digits(1), " ", digits(1)};
         else s = {s, digits($urandom_range(1, 4))};
         if ($urandom_range(9) == 0) s = {s, string'(8'($urandom_range(255)))};
         if (t < terms - 1) begin
            s = {s, rand_op()};
            if ($urandom_range(14) == 0) s = {s, rand_op()};
         end
      end
      if ($urandom_range(14) == 0) s = {s, rand_op()};
      return s;
   endfunction

   task automatic drain();
      req_valid <= 1'b0;
      while (pending_count != 0) @(posedge clock);
      repeat (80) @(posedge clock);
   endtask

   initial begin
      string directed[$];
      int phase_end;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: extremes, each operator, each error kind
      directed = '{"0", "2147483647", "2147483648", "99999999999", "-5+3",
                   "12*34-56/7", "-7/2", "7/0", "1+", "1*", "1/", "*3",
                   "1++2", "--1", "1 2+3", "4x*2", "2147483647*2147483647*4",
                   "100/-3", "8/0+1/0"};
      foreach (directed[i]) send_text(directed[i]);
      send_char(8'hFF, 1'b1);
      send_char(8'h00, 1'b1);
      drain();

      // random phases: none, sender idle, receiver stall, both
      for (int ph = 0; ph < 4; ph++) begin
         send_idle_pct = (ph == 1 || ph == 3) ? 80 : 0;
         recv_stall_pct = (ph == 2) ? 80 : (ph == 3) ? 14 : 0;
         if (ph == 3) send_idle_pct = 14;
         phase_end = char_count + 440;
         while (char_count < phase_end) send_text(rand_expr());
         drain();
      end
      recv_stall_pct = 0;
      repeat (80) @(posedge clock);

      $display("covered %0d characters, %0d results, random idle and stall phases",
               char_count, result_count);
      if (fail_count == 0 && pending_count == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end
endmodule
